/* rtl/fpa_pkg.sv */
// Shared types, codes and constants of the free-list page allocator.
package fpa_pkg;

    // Default width of a page number inside the store
    localparam int PAGE_BITS_DEFAULT = 16;

    // Queue depths between the front, the back and the result port
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Fixed widths from the interface fields
    localparam int CFG_W       = 20;
    localparam int ADDR_W      = 32;
    localparam int WALK_ADDR_W = 33;
    localparam int WALK_PN_W   = 21;
    localparam int PAGE_SHIFT  = 12;

    // Address and page constants
    localparam logic [WALK_ADDR_W-1:0] PAGE_STEP      = 33'h0_0000_1000;
    localparam logic [WALK_ADDR_W-1:0] FOUR_GIB       = 33'h1_0000_0000;
    localparam logic [WALK_PN_W-1:0]   LOW_PAGE_LIMIT = 21'h000100;
    localparam logic [31:0]            REGION_TYPE_RAM = 32'd1;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REGION = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_KERNEL_FIRST = 1'b0,
        CFG_KERNEL_LAST  = 1'b1
    } cfg_index_t;

    // Command classes handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ALLOC,
        CMD_FREE,
        CMD_FREE_BAD,
        CMD_REGION
    } cmd_kind_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ALLOC,
        BK_WALK
    } bk_state_t;

    // Classified command
    typedef struct packed {
        cmd_kind_t              kind;
        logic [ADDR_W-1:0]      addr;   // free address or region base
        logic [WALK_ADDR_W-1:0] lim;    // region end, clipped to 4 GiB
        logic                   walk;   // region is usable RAM below 4 GiB
        logic                   last;   // final region of initialization
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic              granted;
        logic [ADDR_W-1:0] alloc_address;
        status_t           status;
        logic              init_done;
    } res_t;

    // Kernel page range
    typedef struct packed {
        logic [CFG_W-1:0] kernel_first;
        logic [CFG_W-1:0] kernel_last;
    } kcfg_t;

endpackage

/* rtl/fpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fpa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fpa_fifo.sv */
// Small register queue with full and empty flags.
module fpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and count update with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/fpa_front.sv */
// Front end: accepts input beats, classifies them and queues commands.
module fpa_front #(
    parameter int PAGE_BITS = fpa_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            op,
    input  logic [31:0]           page_address,
    input  logic [63:0]           region_base,
    input  logic [63:0]           region_length,
    input  logic [31:0]           region_type,
    input  logic                  last_region,
    input  logic                  cmd_pop,
    output fpa_pkg::cmd_t         cmd,
    output logic                  cmd_empty
);

    localparam int STORE_PAGES = 2 ** PAGE_BITS;
    localparam logic [fpa_pkg::WALK_PN_W-1:0] STORE_LIMIT =
        fpa_pkg::WALK_PN_W'(STORE_PAGES);

    fpa_pkg::cmd_t                cmd_in;
    logic [64:0]                  region_end;
    logic [fpa_pkg::CFG_W-1:0]    free_pn;
    logic [$bits(fpa_pkg::cmd_t)-1:0] cmd_bits;

    // Region end with carry; anything at or above 4 GiB clips there
    assign region_end = {1'b0, region_base} + {1'b0, region_length};
    assign free_pn    = page_address[31:fpa_pkg::PAGE_SHIFT];

    // Classify the beat
    always_comb
    begin
        cmd_in      = '0;
        cmd_in.kind = fpa_pkg::CMD_NOP;
        cmd_in.last = last_region;
        case (op)
            fpa_pkg::OP_ALLOC:
            begin
                cmd_in.kind = fpa_pkg::CMD_ALLOC;
            end
            fpa_pkg::OP_FREE:
            begin
                cmd_in.addr = page_address;
                cmd_in.kind = ({1'b0, free_pn} < STORE_LIMIT) ?
                              fpa_pkg::CMD_FREE : fpa_pkg::CMD_FREE_BAD;
            end
            fpa_pkg::OP_REGION:
            begin
                cmd_in.kind = fpa_pkg::CMD_REGION;
                cmd_in.addr = region_base[31:0];
                cmd_in.walk = (region_type == fpa_pkg::REGION_TYPE_RAM) &&
                              (region_base[63:32] == 32'h0);
                cmd_in.lim  = (region_end[64:32] != 33'h0) ? fpa_pkg::FOUR_GIB :
                              region_end[32:0];
            end
            default:
            begin
                cmd_in.kind = fpa_pkg::CMD_NOP;
            end
        endcase
    end

    // Command queue toward the back end
    fpa_fifo #(
        .WIDTH ($bits(fpa_pkg::cmd_t)),
        .DEPTH (fpa_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd = fpa_pkg::cmd_t'(cmd_bits);

endmodule

/* rtl/fpa_back.sv */
// Back end: owns the free list head and link memory and executes commands.
module fpa_back #(
    parameter int PAGE_BITS = fpa_pkg::PAGE_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fpa_pkg::cmd_t  cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    input  fpa_pkg::kcfg_t kcfg,
    input  logic           res_full,
    output logic           res_push,
    output fpa_pkg::res_t  res_data
);

    localparam int STORE_PAGES = 2 ** PAGE_BITS;
    localparam int LINK_W      = PAGE_BITS + 1;
    localparam logic [fpa_pkg::WALK_PN_W-1:0] STORE_LIMIT =
        fpa_pkg::WALK_PN_W'(STORE_PAGES);

    fpa_pkg::bk_state_t              state_reg, state_next;
    logic [PAGE_BITS-1:0]            head_page_reg, head_page_next;
    logic                            head_valid_reg, head_valid_next;
    logic                            init_reg, init_next;
    logic [fpa_pkg::WALK_ADDR_W-1:0] walk_addr_reg, walk_addr_next;
    logic [fpa_pkg::WALK_ADDR_W-1:0] walk_lim_reg, walk_lim_next;
    logic                            walk_last_reg, walk_last_next;

    logic                            take;
    logic [fpa_pkg::WALK_PN_W-1:0]   walk_pn;
    logic                            walk_on;
    logic                            walk_keep;
    logic                            ram_we, ram_re;
    logic [PAGE_BITS-1:0]            ram_waddr;
    logic [LINK_W-1:0]               ram_wdata, ram_rdata;
    logic [PAGE_BITS-1:0]            cmd_pn;

    // Command taken only with room for its result
    assign take    = (state_reg == fpa_pkg::BK_IDLE) && cmd_valid && !res_full;
    assign cmd_pn  = cmd.addr[fpa_pkg::PAGE_SHIFT +: PAGE_BITS];

    // Walk cursor checks: inside region and inside store
    assign walk_pn   = walk_addr_reg[fpa_pkg::WALK_ADDR_W-1:fpa_pkg::PAGE_SHIFT];
    assign walk_on   = (walk_addr_reg < walk_lim_reg) && (walk_pn < STORE_LIMIT);
    assign walk_keep = (walk_pn >= fpa_pkg::LOW_PAGE_LIMIT) &&
                       !((walk_pn >= {1'b0, kcfg.kernel_first}) &&
                         (walk_pn <= {1'b0, kcfg.kernel_last}));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpa_pkg::BK_IDLE:
            begin
                if (take && (cmd.kind == fpa_pkg::CMD_ALLOC) && head_valid_reg)
                begin
                    state_next = fpa_pkg::BK_ALLOC;
                end
                else if (take && (cmd.kind == fpa_pkg::CMD_REGION) && cmd.walk)
                begin
                    state_next = fpa_pkg::BK_WALK;
                end
            end
            fpa_pkg::BK_ALLOC:
            begin
                state_next = fpa_pkg::BK_IDLE;
            end
            fpa_pkg::BK_WALK:
            begin
                if (!walk_on)
                begin
                    state_next = fpa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = fpa_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs, memory control and datapath updates
    always_comb
    begin
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res_data        = '0;
        res_data.status = fpa_pkg::ST_OK;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = cmd_pn;
        ram_wdata       = {head_valid_reg, head_page_reg};
        head_page_next  = head_page_reg;
        head_valid_next = head_valid_reg;
        init_next       = init_reg;
        walk_addr_next  = walk_addr_reg;
        walk_lim_next   = walk_lim_reg;
        walk_last_next  = walk_last_reg;
        case (state_reg)
            fpa_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        fpa_pkg::CMD_ALLOC:
                        begin
                            if (head_valid_reg)
                            begin
                                ram_re = 1'b1;
                            end
                            else
                            begin
                                res_push        = 1'b1;
                                res_data.status = fpa_pkg::ST_EMPTY;
                            end
                        end
                        fpa_pkg::CMD_FREE:
                        begin
                            ram_we          = 1'b1;
                            head_page_next  = cmd_pn;
                            head_valid_next = 1'b1;
                            res_push        = 1'b1;
                        end
                        fpa_pkg::CMD_FREE_BAD:
                        begin
                            res_push        = 1'b1;
                            res_data.status = fpa_pkg::ST_OUTSIDE;
                        end
                        fpa_pkg::CMD_REGION:
                        begin
                            if (cmd.walk)
                            begin
                                walk_addr_next = {1'b0, cmd.addr};
                                walk_lim_next  = cmd.lim;
                                walk_last_next = cmd.last;
                            end
                            else
                            begin
                                init_next = init_reg | cmd.last;
                                res_push  = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            fpa_pkg::BK_ALLOC:
            begin
                // Link read of the head page has landed
                res_push               = 1'b1;
                res_data.granted       = 1'b1;
                res_data.alloc_address = fpa_pkg::ADDR_W'({head_page_reg, 12'h000});
                head_page_next         = ram_rdata[PAGE_BITS-1:0];
                head_valid_next        = ram_rdata[PAGE_BITS];
            end
            fpa_pkg::BK_WALK:
            begin
                if (walk_on)
                begin
                    if (walk_keep)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = walk_pn[PAGE_BITS-1:0];
                        head_page_next  = walk_pn[PAGE_BITS-1:0];
                        head_valid_next = 1'b1;
                    end
                    walk_addr_next = walk_addr_reg + fpa_pkg::PAGE_STEP;
                end
                else
                begin
                    init_next = init_reg | walk_last_reg;
                    res_push  = 1'b1;
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
        res_data.init_done = init_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fpa_pkg::BK_IDLE;
            head_page_reg  <= '0;
            head_valid_reg <= 1'b0;
            init_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_page_reg  <= head_page_next;
            head_valid_reg <= head_valid_next;
            init_reg       <= init_next;
        end
    end

    // Walk cursor, no reset
    always_ff @(posedge clk)
    begin
        walk_addr_reg <= walk_addr_next;
        walk_lim_reg  <= walk_lim_next;
        walk_last_reg <= walk_last_next;
    end

    // Link memory: valid bit above the next page number
    fpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (STORE_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_page_reg),
        .rdata (ram_rdata)
    );

endmodule

/* rtl/free_list_page_allocator_top.sv */
// Top level of the free-list page allocator: config registers, front, back, result queue.
//
// LIFO allocator of 4 KiB pages over a store of 2^PAGE_BITS pages. Items enter a
// two-beat command queue and results leave through a two-beat result queue, so
// either side may stall on its own. In the back end a free, a rejected free, an
// empty-list allocation, an unused op code and a region that is not walked are
// each finished in BK_IDLE; a granted allocation goes on to BK_ALLOC, where the
// registered read of the link memory lands. A walked region steps page by page in
// BK_WALK, from its base up to the lower of its end and the end of the store, and
// each pushed page is one write to the single link-memory write port. The link memory
// holds undefined contents after reset and needs no clearing pass; the block is
// ready as soon as reset is released. Configuration writes are always accepted.
module free_list_page_allocator_top #(
    parameter int PAGE_BITS = fpa_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // item queue side
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                op,
    input  logic [31:0]               page_address,
    input  logic [63:0]               region_base,
    input  logic [63:0]               region_length,
    input  logic [31:0]               region_type,
    input  logic                      last_region,
    // result queue side
    output logic                      empty,
    input  logic                      pop,
    output logic                      granted,
    output logic [31:0]               alloc_address,
    output logic [1:0]                status,
    output logic                      init_done,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [fpa_pkg::CFG_W-1:0] cfg_data
);

    fpa_pkg::kcfg_t kcfg_reg, kcfg_next;
    fpa_pkg::cmd_t  cmd;
    logic           cmd_empty;
    logic           cmd_pop;
    logic           res_full;
    logic           res_push;
    fpa_pkg::res_t  res_data;
    fpa_pkg::res_t  res_head;
    logic [$bits(fpa_pkg::res_t)-1:0] res_bits;

    // Configuration register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        kcfg_next = kcfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fpa_pkg::CFG_KERNEL_FIRST: kcfg_next.kernel_first = cfg_data;
                fpa_pkg::CFG_KERNEL_LAST:  kcfg_next.kernel_last  = cfg_data;
                default:                   kcfg_next = kcfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcfg_reg <= '0;
        end
        else
        begin
            kcfg_reg <= kcfg_next;
        end
    end

    // Front end with command queue
    fpa_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .page_address  (page_address),
        .region_base   (region_base),
        .region_length (region_length),
        .region_type   (region_type),
        .last_region   (last_region),
        .cmd_pop       (cmd_pop),
        .cmd           (cmd),
        .cmd_empty     (cmd_empty)
    );

    // Back end with free list
    fpa_back #(
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (!cmd_empty),
        .cmd_pop   (cmd_pop),
        .kcfg      (kcfg_reg),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue
    fpa_fifo #(
        .WIDTH ($bits(fpa_pkg::res_t)),
        .DEPTH (fpa_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_head      = fpa_pkg::res_t'(res_bits);
    assign granted       = res_head.granted;
    assign alloc_address = res_head.alloc_address;
    assign status        = res_head.status;
    assign init_done     = res_head.init_done;

    // The back end reserves result space before taking a command
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result beat pushed into a full result queue");

    // A granted page carries status ok and a page-aligned address
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.granted) |->
        ((res_data.status == fpa_pkg::ST_OK) && (res_data.alloc_address[11:0] == 12'h000)))
        else $error("granted result with bad status or unaligned address");

    // Initialization flag never drops between delivered results
    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && init_done) |=> (empty || init_done))
        else $error("init_done fell after being reported");

endmodule
